FILE: rtl/sparse_row_dot_product_accumulator_core_assert.svh
// Assertion macros for the RTL of the sparse row engine.
// Both expect a signal named clk in the including scope; SPRD_ASSERT also rst.
`ifndef SPARSE_ROW_DOT_PRODUCT_ACCUMULATOR_CORE_ASSERT_SVH
`define SPARSE_ROW_DOT_PRODUCT_ACCUMULATOR_CORE_ASSERT_SVH

// Checked at every rising edge outside reset
`define SPRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sprd: assertion failed");

// Checked at every rising edge, reset included
`define SPRD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sprd: assertion failed");

`endif

FILE: rtl/sprd_pkg.sv
package sprd_pkg;

  // Lane count of the item format
  localparam int LANES     = 4;
  localparam int LANES_MAX = 16;

  // Operand, product and accumulator widths (Q16.16 in, Q32.32 out)
  localparam int OPND_W    = 32;
  localparam int PROD_W    = 64;
  localparam int ACC_W     = 64;
  // Room for the exact sum of up to LANES_MAX products
  localparam int SUM_MAX_W = PROD_W + $clog2(LANES_MAX) + 1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Control travelling alongside each transaction
  typedef struct packed {
    logic valid;
    logic row_end;
  } sprd_ctl_t;

  // A saturating update x -> clamp(x + s, lo, hi), with lo <= hi.
  // A run of saturating adds composes into one function of this form.
  typedef struct packed {
    logic signed [SUM_MAX_W-1:0] s;
    logic signed [ACC_W-1:0]     lo;
    logic signed [ACC_W-1:0]     hi;
  } sprd_fn_t;

  // Clamp a wide value into [lo, hi]
  function automatic logic signed [ACC_W-1:0] sprd_clamp(
    input logic signed [SUM_MAX_W-1:0] v,
    input logic signed [ACC_W-1:0]     lo,
    input logic signed [ACC_W-1:0]     hi
  );
    logic signed [SUM_MAX_W-1:0] lo_x;
    logic signed [SUM_MAX_W-1:0] hi_x;
    logic signed [ACC_W-1:0]     r;
    lo_x = SUM_MAX_W'(lo);
    hi_x = SUM_MAX_W'(hi);
    if (v < lo_x) begin
      r = lo;
    end else if (v > hi_x) begin
      r = hi;
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  // Function a applied first, then b
  function automatic sprd_fn_t sprd_compose(input sprd_fn_t a, input sprd_fn_t b);
    logic signed [SUM_MAX_W-1:0] as;
    logic signed [SUM_MAX_W-1:0] bs;
    logic signed [SUM_MAX_W-1:0] alo;
    logic signed [SUM_MAX_W-1:0] ahi;
    sprd_fn_t r;
    as  = a.s;
    bs  = b.s;
    alo = SUM_MAX_W'(a.lo);
    ahi = SUM_MAX_W'(a.hi);
    r.s  = as + bs;
    r.lo = sprd_clamp(alo + bs, b.lo, b.hi);
    r.hi = sprd_clamp(ahi + bs, b.lo, b.hi);
    return r;
  endfunction

  // Apply a composed update to the accumulator
  function automatic logic signed [ACC_W-1:0] sprd_apply(
    input sprd_fn_t                f,
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [SUM_MAX_W-1:0] acc_x;
    logic signed [SUM_MAX_W-1:0] fs;
    acc_x = SUM_MAX_W'(acc);
    fs    = f.s;
    return sprd_clamp(acc_x + fs, f.lo, f.hi);
  endfunction

endpackage

FILE: rtl/sparse_row_dot_product_accumulator_core.sv
// Sparse row dot-product engine. Each transaction carries four signed Q16.16
// coefficient/vector pairs and a row_end flag; products are added in lane
// order into a saturating Q32.32 row sum, and a transaction with row_end set
// produces row_sum (including its own products) and clears the sum. One
// transaction is taken per cycle while in_ready is high. A row_sum appears on
// out_valid once the closing transaction has passed one multiplier stage in
// each lane, two levels of the lane-merging tree and the accumulator update
// into the output register. in_ready drops only while a row-closing
// transaction sits at the accumulator and the previous row_sum has not yet been taken.
`include "sparse_row_dot_product_accumulator_core_assert.svh"

module sparse_row_dot_product_accumulator_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sprd_pkg::OPND_W-1:0]   coef_0,
  input  logic signed [sprd_pkg::OPND_W-1:0]   coef_1,
  input  logic signed [sprd_pkg::OPND_W-1:0]   coef_2,
  input  logic signed [sprd_pkg::OPND_W-1:0]   coef_3,
  input  logic signed [sprd_pkg::OPND_W-1:0]   vec_0,
  input  logic signed [sprd_pkg::OPND_W-1:0]   vec_1,
  input  logic signed [sprd_pkg::OPND_W-1:0]   vec_2,
  input  logic signed [sprd_pkg::OPND_W-1:0]   vec_3,
  input  logic                                 row_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sprd_pkg::ACC_W-1:0]    row_sum
);
  import sprd_pkg::*;

  logic signed [OPND_W-1:0] coef_a [LANES];
  logic signed [OPND_W-1:0] vec_a  [LANES];
  logic signed [PROD_W-1:0] prod   [LANES];

  sprd_ctl_t                p_ctl;
  sprd_ctl_t                m_ctl;
  sprd_fn_t                 m_fn;
  logic                     adv;
  logic                     fire;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;

  assign coef_a[0] = coef_0;
  assign coef_a[1] = coef_1;
  assign coef_a[2] = coef_2;
  assign coef_a[3] = coef_3;
  assign vec_a[0]  = vec_0;
  assign vec_a[1]  = vec_1;
  assign vec_a[2]  = vec_2;
  assign vec_a[3]  = vec_3;

  // Pipeline moves unless a row-closing transaction waits on the output
  assign adv      = !m_ctl.valid || !m_ctl.row_end || !out_valid || out_ready;
  assign in_ready = adv;
  assign fire     = m_ctl.valid && adv;

  // Lane multipliers
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    sprd_lane u_lane (
      .clk  (clk),
      .en   (adv),
      .coef (coef_a[k]),
      .vec  (vec_a[k]),
      .prod (prod[k])
    );
  end

  // Control for the multiplier stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl <= '0;
    end else if (adv) begin
      p_ctl <= '{valid: in_valid, row_end: row_end};
    end
  end

  sprd_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .prod    (prod),
    .ctl_in  (p_ctl),
    .fn_out  (m_fn),
    .ctl_out (m_ctl)
  );

  // Accumulator: one add and clamp per transaction
  assign acc_next = sprd_apply(m_fn, acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (fire) begin
      if (m_ctl.row_end) begin
        acc <= '0;
      end else begin
        acc <= acc_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && m_ctl.row_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && m_ctl.row_end) begin
      row_sum <= acc_next;
    end
  end

  // Checks
  `SPRD_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid && acc == '0)
  `SPRD_ASSERT(a_row_close_emits, fire && m_ctl.row_end |=> out_valid && acc == '0)
  `SPRD_ASSERT(a_bounds_ordered, m_ctl.valid |-> m_fn.lo <= m_fn.hi)
  `SPRD_ASSERT(a_stall_cause, !in_ready |-> out_valid && !out_ready && m_ctl.row_end)
  `SPRD_ASSERT(a_acc_holds, !fire |=> $stable(acc))

endmodule

FILE: rtl/sprd_lane.sv
// One lane: registered signed coefficient x vector product
module sprd_lane (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [sprd_pkg::OPND_W-1:0]   coef,
  input  logic signed [sprd_pkg::OPND_W-1:0]   vec,
  output logic signed [sprd_pkg::PROD_W-1:0]   prod
);
  import sprd_pkg::*;

  logic signed [PROD_W-1:0] prod_next;

  // Exact Q32.32 product
  assign prod_next = coef * vec;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
    end
  end

endmodule

FILE: rtl/sprd_merge.sv
// Registered tree that folds the lane products, in lane order, into one
// saturating update. Each tree level is registered and advances while en is high.
module sprd_merge #(
  parameter int LANES = sprd_pkg::LANES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic signed [sprd_pkg::PROD_W-1:0] prod [LANES],
  input  sprd_pkg::sprd_ctl_t                ctl_in,
  output sprd_pkg::sprd_fn_t                 fn_out,
  output sprd_pkg::sprd_ctl_t                ctl_out
);
  import sprd_pkg::*;

  // At least one level, so a single lane still has a registered stage
  localparam int LVL = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int NP  = 1 << LVL;

  sprd_fn_t  leaf   [NP];
  sprd_fn_t  fn_q   [LVL][NP];
  sprd_ctl_t ctl_q  [LVL];

  // Leaves: one plain saturating add per lane, padding lanes add nothing
  for (genvar j = 0; j < NP; j++) begin : g_leaf
    if (j < LANES) begin : g_used
      assign leaf[j] = '{s: SUM_MAX_W'(prod[j]), lo: ACC_MIN, hi: ACC_MAX};
    end else begin : g_pad
      assign leaf[j] = '{s: '0, lo: ACC_MIN, hi: ACC_MAX};
    end
  end

  // Tree levels: lower lane first in every pair
  for (genvar l = 0; l < LVL; l++) begin : g_lvl
    for (genvar j = 0; j < NP; j++) begin : g_node
      if (j < (NP >> (l + 1))) begin : g_live
        if (l == 0) begin : g_first
          always_ff @(posedge clk) begin
            if (en) begin
              fn_q[l][j] <= sprd_compose(leaf[2*j], leaf[2*j+1]);
            end
          end
        end else begin : g_inner
          always_ff @(posedge clk) begin
            if (en) begin
              fn_q[l][j] <= sprd_compose(fn_q[l-1][2*j], fn_q[l-1][2*j+1]);
            end
          end
        end
      end else begin : g_idle
        always_ff @(posedge clk) begin
          fn_q[l][j] <= '{s: '0, lo: ACC_MIN, hi: ACC_MAX};
        end
      end
    end
  end

  // Control shifts with the tree
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LVL; l++) begin
        ctl_q[l] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= ctl_in;
      for (int l = 1; l < LVL; l++) begin
        ctl_q[l] <= ctl_q[l-1];
      end
    end
  end

  assign fn_out  = fn_q[LVL-1][0];
  assign ctl_out = ctl_q[LVL-1];

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import sprd_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int WATCHDOG_MAX = 1000;
  localparam int LONG_HOLD    = 80;
  localparam int TAIL_CYCLES  = 20;
  localparam int MAX_REPORTS  = 10;

  // Q16.16 corner operands
  localparam logic [OPND_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [OPND_W-1:0] Q_MIN     = 32'h8000_0000;
  localparam logic [OPND_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [OPND_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [OPND_W-1:0] Q_LSB     = 32'h0000_0001;
  localparam logic [OPND_W-1:0] Q_ALL1    = 32'hFFFF_FFFF;

  typedef enum int {
    OPND_FULL,
    OPND_SMALL,
    OPND_CORNER,
    OPND_MIXED
  } opnd_style_e;

  typedef struct packed {
    logic [LANES-1:0][OPND_W-1:0] coef;
    logic [LANES-1:0][OPND_W-1:0] vec;
    logic                         row_end;
  } row_item_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [OPND_W-1:0] coef_0 = '0;
  logic signed [OPND_W-1:0] coef_1 = '0;
  logic signed [OPND_W-1:0] coef_2 = '0;
  logic signed [OPND_W-1:0] coef_3 = '0;
  logic signed [OPND_W-1:0] vec_0 = '0;
  logic signed [OPND_W-1:0] vec_1 = '0;
  logic signed [OPND_W-1:0] vec_2 = '0;
  logic signed [OPND_W-1:0] vec_3 = '0;
  logic                     row_end = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [ACC_W-1:0]  row_sum;

  // Testbench state
  logic signed [ACC_W-1:0] row_total = '0;
  logic signed [ACC_W-1:0] expected_sums[$];
  int                      mismatch_count = 0;
  int                      items_sent = 0;
  bit                      idling = 1'b1;
  logic                    hold_off_req = 1'b0;

  sparse_row_dot_product_accumulator_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .coef_0    (coef_0),
    .coef_1    (coef_1),
    .coef_2    (coef_2),
    .coef_3    (coef_3),
    .vec_0     (vec_0),
    .vec_1     (vec_1),
    .vec_2     (vec_2),
    .vec_3     (vec_3),
    .row_end   (row_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .row_sum   (row_sum)
  );

  // Clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Saturating add of one Q32.32 lane product into the row sum
  function automatic logic signed [ACC_W-1:0] sat_accumulate(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [ACC_W:0] wide;
    logic signed [ACC_W-1:0] r;
    wide = {acc[ACC_W-1], acc} + {prod[PROD_W-1], prod};
    if (wide[ACC_W] != wide[ACC_W-1]) begin
      r = wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r = wide[ACC_W-1:0];
    end
    return r;
  endfunction

  // Fold one transaction into the predicted row sum, lane 0 first
  task automatic accumulate_item(input row_item_t it);
    logic signed [PROD_W-1:0] prod;
    logic signed [OPND_W-1:0] c;
    logic signed [OPND_W-1:0] x;
    for (int k = 0; k < LANES; k++) begin
      c = it.coef[k];
      x = it.vec[k];
      prod = PROD_W'(c) * PROD_W'(x);
      row_total = sat_accumulate(row_total, prod);
    end
    if (it.row_end) begin
      expected_sums.push_back(row_total);
      row_total = '0;
    end
  endtask

  function automatic row_item_t make_item(
    input logic [OPND_W-1:0] c0, input logic [OPND_W-1:0] c1,
    input logic [OPND_W-1:0] c2, input logic [OPND_W-1:0] c3,
    input logic [OPND_W-1:0] v0, input logic [OPND_W-1:0] v1,
    input logic [OPND_W-1:0] v2, input logic [OPND_W-1:0] v3,
    input logic              re
  );
    row_item_t it;
    it.coef    = {c3, c2, c1, c0};
    it.vec     = {v3, v2, v1, v0};
    it.row_end = re;
    return it;
  endfunction

  function automatic logic [OPND_W-1:0] rand_operand(input opnd_style_e style);
    logic [OPND_W-1:0] r;
    opnd_style_e       s;
    s = style;
    if (s == OPND_MIXED) begin
      s = opnd_style_e'($urandom_range(0, 2));
    end
    case (s)
      OPND_SMALL: begin
        r = OPND_W'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      end
      OPND_CORNER: begin
        case ($urandom_range(0, 6))
          0: r = Q_MAX;
          1: r = Q_MIN;
          2: r = Q_ONE;
          3: r = Q_NEG_ONE;
          4: r = Q_LSB;
          5: r = Q_ALL1;
          default: r = '0;
        endcase
      end
      default: begin
        r = $urandom;
      end
    endcase
    return r;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send_item(input row_item_t it);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    coef_0   <= it.coef[0];
    coef_1   <= it.coef[1];
    coef_2   <= it.coef[2];
    coef_3   <= it.coef[3];
    vec_0    <= it.vec[0];
    vec_1    <= it.vec[1];
    vec_2    <= it.vec[2];
    vec_3    <= it.vec[3];
    row_end  <= it.row_end;
    do @(posedge clk); while (!in_ready);
    accumulate_item(it);
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding row_sum
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_sums.size() != 0);
  endtask

  task automatic send_random_row(input int len);
    row_item_t   it;
    opnd_style_e style;
    style = opnd_style_e'($urandom_range(0, 3));
    for (int i = 0; i < len; i++) begin
      for (int k = 0; k < LANES; k++) begin
        it.coef[k] = rand_operand(style);
        it.vec[k]  = rand_operand(style);
      end
      it.row_end = (i == len - 1);
      send_item(it);
    end
  endtask

  task automatic report_mismatch(
    input string                   what,
    input logic signed [ACC_W-1:0] exp_v,
    input logic signed [ACC_W-1:0] act_v
  );
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("row_sum mismatch (%s): expected %h, got %h", what, exp_v, act_v);
    end
  endtask

  // Extreme operands, signs and unit values
  task automatic test_corner_products();
    send_item(make_item('0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
    send_item(make_item(Q_MAX, '0, '0, '0, Q_MAX, '0, '0, '0, 1'b1));
    send_item(make_item(Q_MIN, '0, '0, '0, Q_MIN, '0, '0, '0, 1'b1));
    send_item(make_item('0, Q_MIN, '0, '0, '0, Q_MAX, '0, '0, 1'b1));
    send_item(make_item(Q_ONE, Q_NEG_ONE, Q_LSB, Q_ALL1,
                        Q_ONE, Q_ONE, Q_ALL1, Q_ALL1, 1'b1));
    send_item(make_item(Q_LSB, Q_LSB, Q_LSB, Q_LSB,
                        Q_LSB, Q_LSB, Q_LSB, Q_LSB, 1'b1));
    send_item(make_item(Q_ALL1, Q_MAX, Q_MIN, Q_NEG_ONE,
                        Q_MIN, Q_ALL1, Q_ALL1, Q_MIN, 1'b1));
  endtask

  // Saturation on each add, where lane order changes the answer
  task automatic test_saturation_order();
    send_item(make_item(Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                        Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
    send_item(make_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                        Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
    send_item(make_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                        Q_MIN, Q_MIN, Q_MIN, Q_MAX, 1'b1));
    send_item(make_item(Q_MIN, Q_MIN, Q_MIN, Q_MAX,
                        Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
    send_item(make_item(Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                        Q_MIN, Q_MAX, Q_MAX, Q_MIN, 1'b1));
    // sum pinned at the top across items, then pulled back down
    send_item(make_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                        Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
    send_item(make_item(Q_MIN, '0, '0, '0, Q_MAX, '0, '0, '0, 1'b1));
  endtask

  // Row that runs over many transactions before row_end
  task automatic test_open_row();
    send_item(make_item(Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                        Q_ONE, Q_NEG_ONE, Q_ONE, Q_ONE, 1'b0));
    send_item(make_item(Q_MAX, Q_LSB, '0, Q_ALL1,
                        Q_ONE, Q_ALL1, Q_MAX, Q_ONE, 1'b0));
    send_item(make_item(Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                        Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0));
    send_item(make_item(Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                        Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0));
    send_item(make_item(Q_MIN, Q_NEG_ONE, '0, '0,
                        Q_MAX, Q_ONE, '0, '0, 1'b0));
    send_item(make_item('0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
  endtask

  // Random rows of mostly short length, some long ones
  task automatic test_random_rows(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_random_row($urandom_range(10, 24));
      end else begin
        send_random_row($urandom_range(1, 6));
      end
    end
  endtask

  // Receiver holds off while single-transaction rows keep coming
  task automatic test_output_backpressure();
    hold_off_req <= 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_random_row(1);
    end
    drain_results();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_streaming(input int n_items);
    idling = 1'b0;
    test_random_rows(n_items);
  endtask

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req <= 1'b0;
        out_ready    <= 1'b1;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("unexpected transaction", '0, row_sum);
      end else if (row_sum !== expected_sums[0]) begin
        report_mismatch("value", expected_sums.pop_front(), row_sum);
      end else begin
        void'(expected_sums.pop_front());
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_MAX) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("sparse_row_dot_product_accumulator_core verification failed");
    $finish;
  end

  // Test sequence
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_corner_products();
    test_saturation_order();
    test_open_row();
    test_random_rows(1050);
    test_output_backpressure();
    test_streaming(340);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sparse_row_dot_product_accumulator_core verification clean");
    end else begin
      $display("sparse_row_dot_product_accumulator_core verification failed");
    end
    $finish;
  end

endmodule
